// ----- hdl/arp_resolver_with_pending_queue_defines.svh -----
// assertion macros for the arp resolver checker
`ifndef ARP_RESOLVER_WITH_PENDING_QUEUE_DEFINES_SVH
`define ARP_RESOLVER_WITH_PENDING_QUEUE_DEFINES_SVH
// implication checked on every edge outside reset
`define ARP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("arp check failed");
// next-cycle implication outside reset
`define ARP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("arp check failed");
`endif

// ----- hdl/arp_pkg.sv -----
// shared types and constants of the arp resolver
`timescale 1ns / 1ps
package arp_pkg;
    localparam int CACHE_ENTRIES   = 16;
    localparam int REQUEST_ENTRIES = 16;
    localparam int QUEUE_DEPTH     = 16;
    localparam int CW = $clog2(CACHE_ENTRIES) > 0 ? $clog2(CACHE_ENTRIES) : 1;
    localparam int RW = $clog2(REQUEST_ENTRIES) > 0 ? $clog2(REQUEST_ENTRIES) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH) > 0 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int FQ_DEPTH = 2;

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_RECV = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] KIND_IPV4    = 3'd0;
    localparam logic [2:0] KIND_ARP_REQ = 3'd1;
    localparam logic [2:0] KIND_ARP_REP = 3'd2;
    localparam logic [2:0] KIND_DELIVER = 3'd3;
    localparam logic [2:0] KIND_DROP    = 3'd4;

    localparam logic [1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [1:0] REG_OWN_IP   = 2'd1;
    localparam logic [1:0] REG_RETRY    = 2'd2;
    localparam logic [1:0] REG_LIFETIME = 2'd3;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] RETRY_RESET    = 16'd5000;
    localparam logic [31:0] LIFETIME_RESET = 32'd30000;

    // classified command handed from the front to the back
    typedef enum logic [1:0] {
        CMD_SEND, CMD_ARP, CMD_TICK
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] ip;
        logic [15:0] tag;
        logic [47:0] mac;
        logic        answer;
        logic [31:0] elapsed;
    } t_job;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] dst_mac;
        logic [15:0] out_tag;
        logic [31:0] arp_target_ip_out;
        logic [47:0] arp_target_mac_out;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SEND_DEC, ST_SEND_Q, ST_LEARN, ST_FLUSH,
        ST_REPLY, ST_AGE
    } t_state;
endpackage

// ----- hdl/arp_if.sv -----
// valid/ready channel interfaces of the arp resolver
`timescale 1ns / 1ps
interface arp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] next_hop_ip;
    logic [15:0] payload_tag;
    logic [47:0] frame_dst_mac;
    logic [15:0] ether_type;
    logic        parse_ok;
    logic [15:0] arp_opcode;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip_in;
    logic [31:0] elapsed_ms;
    modport source (output valid, action, next_hop_ip, payload_tag, frame_dst_mac,
        ether_type, parse_ok, arp_opcode, arp_sender_ip, arp_sender_mac,
        arp_target_ip_in, elapsed_ms, input ready);
    modport sink (input valid, action, next_hop_ip, payload_tag, frame_dst_mac,
        ether_type, parse_ok, arp_opcode, arp_sender_ip, arp_sender_mac,
        arp_target_ip_in, elapsed_ms, output ready);
endinterface

interface arp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [47:0] dst_mac;
    logic [15:0] out_tag;
    logic [31:0] arp_target_ip_out;
    logic [47:0] arp_target_mac_out;
    logic        last;
    modport source (output valid, kind, dst_mac, out_tag, arp_target_ip_out,
        arp_target_mac_out, last, input ready);
    modport sink (input valid, kind, dst_mac, out_tag, arp_target_ip_out,
        arp_target_mac_out, last, output ready);
endinterface

interface arp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/arp_front.sv -----
// front end: filters received frames and classifies requests into jobs
`timescale 1ns / 1ps
module arp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    arp_in_if.sink          in_ch,
    input  logic [47:0]     i_own_mac,
    input  logic [31:0]     i_own_ip,
    // ipv4 delivery result goes straight to the back end's emit path
    output logic            o_job_valid,
    output arp_pkg::t_job   o_job,
    input  logic            i_job_ready,
    output logic            o_dlv_valid,
    output logic [15:0]     o_dlv_tag,
    input  logic            i_dlv_ready
);
    import arp_pkg::*;

    t_job  r_q [FQ_DEPTH];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic        r_dv;
    logic [15:0] r_dtag;
    logic for_us, is_job, is_dlv, acc, pop;
    t_job nj;

    assign for_us = (in_ch.frame_dst_mac == i_own_mac || in_ch.frame_dst_mac == MAC_BCAST)
                    && in_ch.parse_ok;
    assign is_dlv = in_ch.action == ACT_RECV && for_us && in_ch.ether_type == ETH_IPV4;
    assign is_job = in_ch.action == ACT_SEND || in_ch.action == ACT_TICK ||
                    (in_ch.action == ACT_RECV && for_us && in_ch.ether_type == ETH_ARP);
    // deliveries and jobs must stay in order: hold deliveries until the queue drains
    assign in_ch.ready = is_dlv ? (!r_dv && r_cnt == 2'd0 && i_job_ready) :
                         is_job ? (r_cnt != 2'(FQ_DEPTH) && !r_dv) : 1'b1;
    assign acc = in_ch.valid && in_ch.ready;
    assign pop = o_job_valid && i_job_ready;

    always_comb begin
        nj.cmd = (in_ch.action == ACT_SEND) ? CMD_SEND :
                 (in_ch.action == ACT_TICK) ? CMD_TICK : CMD_ARP;
        nj.ip = (in_ch.action == ACT_SEND) ? in_ch.next_hop_ip : in_ch.arp_sender_ip;
        nj.tag = in_ch.payload_tag;
        nj.mac = in_ch.arp_sender_mac;
        nj.answer = in_ch.arp_opcode == ARP_OP_REQUEST && in_ch.arp_target_ip_in == i_own_ip;
        nj.elapsed = in_ch.elapsed_ms;
        n_cnt = r_cnt + 2'(acc && is_job) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_dv  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (acc && is_job) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            if (acc && is_dlv) r_dv <= 1'b1;
            else if (i_dlv_ready) r_dv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_job) r_q[r_wr] <= nj;
        if (acc && is_dlv) r_dtag <= in_ch.payload_tag;
    end

    assign o_job_valid = r_cnt != 2'd0;
    assign o_job = r_q[r_rd];
    assign o_dlv_valid = r_dv;
    assign o_dlv_tag = r_dtag;
endmodule

// ----- hdl/arp_back.sv -----
// back end: walks cache, requests, queue one entry a cycle unless stalled
`timescale 1ns / 1ps
module arp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  arp_pkg::t_job   i_job,
    output logic            o_job_ready,
    input  logic            i_dlv_valid,
    input  logic [15:0]     i_dlv_tag,
    output logic            o_dlv_ready,
    input  logic [15:0]     i_retry,
    input  logic [31:0]     i_lifetime,
    arp_out_if.source       out_ch
);
    import arp_pkg::*;

    t_state r_st, n_st;
    t_job   r_job;
    logic [63:0] r_now;
    logic [CACHE_ENTRIES-1:0]   r_cv;
    logic [31:0] r_cip [CACHE_ENTRIES];
    logic [47:0] r_cmac [CACHE_ENTRIES];
    logic [63:0] r_cst [CACHE_ENTRIES];
    logic [REQUEST_ENTRIES-1:0] r_rv;
    logic [31:0] r_rip [REQUEST_ENTRIES];
    logic [63:0] r_rst [REQUEST_ENTRIES];
    logic [31:0] r_pip [QUEUE_DEPTH];
    logic [15:0] r_ptag [QUEUE_DEPTH];
    logic [QCW-1:0] r_qc;

    // scan bookkeeping
    logic [8:0]  r_i;
    logic        r_chit, r_rhit, r_cfree, r_rfree;
    logic [CW-1:0] r_cidx, r_cold;
    logic [RW-1:0] r_ridx, r_rold;
    logic [63:0] r_cage, r_rage;
    logic [QCW-1:0] r_k;
    // one flushed datagram held back until its last flag is known
    logic        r_hold;
    logic [15:0] r_htag;

    // result register
    logic r_ov;
    t_res r_o, n_o;
    logic do_emit;
    logic ci_ok, ri_ok, q_more, q_match;
    logic [CW-1:0] ci;
    logic [RW-1:0] ri;
    logic [QW-1:0] qi;
    logic [63:0] cage, rage;
    logic slot_free, send_req;

    assign ci = r_i[CW-1:0];
    assign ri = r_i[RW-1:0];
    assign qi = r_i[QW-1:0];
    assign ci_ok = r_i < 9'(CACHE_ENTRIES);
    assign ri_ok = r_i < 9'(REQUEST_ENTRIES);
    assign q_more = r_i < 9'(r_qc);
    assign q_match = q_more && r_pip[qi] == r_job.ip;
    assign cage = r_now - r_cst[ci];
    assign rage = r_now - r_rst[ri];

    assign out_ch.valid = r_ov;
    assign out_ch.kind = r_o.kind;
    assign out_ch.dst_mac = r_o.dst_mac;
    assign out_ch.out_tag = r_o.out_tag;
    assign out_ch.arp_target_ip_out = r_o.arp_target_ip_out;
    assign out_ch.arp_target_mac_out = r_o.arp_target_mac_out;
    assign out_ch.last = r_o.last;

    assign slot_free = !r_ov || out_ch.ready;
    assign o_job_ready = r_st == ST_IDLE && !i_dlv_valid;
    assign o_dlv_ready = r_st == ST_IDLE && slot_free;

    assign send_req = !r_rhit || (r_now - r_rst[r_ridx] > {48'd0, i_retry});

    always_comb begin
        n_st = r_st;
        n_o = '0;
        do_emit = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_dlv_valid && slot_free) begin
                    do_emit = 1'b1;
                    n_o.kind = KIND_DELIVER;
                    n_o.out_tag = i_dlv_tag;
                    n_o.last = 1'b1;
                end else if (i_job_valid && !i_dlv_valid) begin
                    n_st = (i_job.cmd == CMD_TICK) ? ST_AGE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!ci_ok && !ri_ok)
                    n_st = (r_job.cmd == CMD_SEND) ? ST_SEND_DEC : ST_LEARN;
            end
            ST_SEND_DEC: begin
                if (slot_free) begin
                    if (r_chit) begin
                        do_emit = 1'b1;
                        n_o.kind = KIND_IPV4;
                        n_o.dst_mac = r_cmac[r_cidx];
                        n_o.out_tag = r_job.tag;
                        n_o.last = 1'b1;
                        n_st = ST_IDLE;
                    end else if (send_req) begin
                        do_emit = 1'b1;
                        n_o.kind = KIND_ARP_REQ;
                        n_o.dst_mac = MAC_BCAST;
                        n_o.arp_target_ip_out = r_job.ip;
                        n_o.last = r_qc != QCW'(QUEUE_DEPTH) ? 1'b1 : 1'b0;
                        n_st = ST_SEND_Q;
                    end else begin
                        n_st = ST_SEND_Q;
                    end
                end
            end
            ST_SEND_Q: begin
                if (r_qc == QCW'(QUEUE_DEPTH)) begin
                    if (slot_free) begin
                        do_emit = 1'b1;
                        n_o.kind = KIND_DROP;
                        n_o.out_tag = r_job.tag;
                        n_o.last = 1'b1;
                        n_st = ST_IDLE;
                    end
                end else begin
                    n_st = ST_IDLE;
                end
            end
            ST_LEARN: n_st = ST_FLUSH;
            ST_FLUSH: begin
                if (!q_more) begin
                    if (!r_hold) begin
                        n_st = r_job.answer ? ST_REPLY : ST_IDLE;
                    end else if (slot_free) begin
                        // held datagram is final unless a reply follows
                        do_emit = 1'b1;
                        n_o.kind = KIND_IPV4;
                        n_o.dst_mac = r_job.mac;
                        n_o.out_tag = r_htag;
                        n_o.last = !r_job.answer;
                        n_st = r_job.answer ? ST_REPLY : ST_IDLE;
                    end
                end else if (q_match && r_hold && slot_free) begin
                    // another match follows, so the held one is not last
                    do_emit = 1'b1;
                    n_o.kind = KIND_IPV4;
                    n_o.dst_mac = r_job.mac;
                    n_o.out_tag = r_htag;
                end
            end
            ST_REPLY: begin
                if (slot_free) begin
                    do_emit = 1'b1;
                    n_o.kind = KIND_ARP_REP;
                    n_o.dst_mac = r_job.mac;
                    n_o.arp_target_ip_out = r_job.ip;
                    n_o.arp_target_mac_out = r_job.mac;
                    n_o.last = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            ST_AGE: begin
                if (!ci_ok) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_now <= '0;
            r_cv <= '0;
            r_rv <= '0;
            r_qc <= '0;
            r_hold <= 1'b0;
            r_i <= '0;
        end else begin
            r_st <= n_st;
            if (do_emit) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    r_i <= '0;
                    r_chit <= 1'b0; r_rhit <= 1'b0;
                    r_cfree <= 1'b0; r_rfree <= 1'b0;
                    r_cold <= '0; r_rold <= '0;
                    r_cage <= '0; r_rage <= '0;
                    r_k <= '0;
                    r_hold <= 1'b0;
                    if (o_job_ready && i_job_valid) begin
                        r_job <= i_job;
                        if (i_job.cmd == CMD_TICK) r_now <= r_now + 64'(i_job.elapsed);
                    end
                end
                ST_SCAN: begin
                    if (!ci_ok && !ri_ok) r_i <= '0;
                    else r_i <= r_i + 9'd1;
                    if (ci_ok) begin
                        if (r_cv[ci] && r_cip[ci] == r_job.ip && !r_chit) begin
                            r_chit <= 1'b1; r_cidx <= ci;
                        end
                        if (!r_cv[ci] && !r_cfree) begin
                            r_cfree <= 1'b1; r_cold <= ci;
                        end else if (r_cv[ci] && !r_cfree && (r_i == 9'd0 || cage > r_cage)) begin
                            r_cold <= ci; r_cage <= cage;
                        end
                    end
                    if (ri_ok) begin
                        if (r_rv[ri] && r_rip[ri] == r_job.ip && !r_rhit) begin
                            r_rhit <= 1'b1; r_ridx <= ri;
                        end
                        if (!r_rv[ri] && !r_rfree) begin
                            r_rfree <= 1'b1; r_rold <= ri;
                        end else if (r_rv[ri] && !r_rfree && (r_i == 9'd0 || rage > r_rage)) begin
                            r_rold <= ri; r_rage <= rage;
                        end
                    end
                end
                ST_SEND_DEC: begin
                    if (slot_free && !r_chit && send_req) begin
                        if (r_rhit) r_rst[r_ridx] <= r_now;
                        else begin
                            r_rv[r_rold] <= 1'b1;
                            r_rip[r_rold] <= r_job.ip;
                            r_rst[r_rold] <= r_now;
                        end
                    end
                end
                ST_SEND_Q: begin
                    if (r_qc != QCW'(QUEUE_DEPTH)) begin
                        r_pip[r_qc[QW-1:0]] <= r_job.ip;
                        r_ptag[r_qc[QW-1:0]] <= r_job.tag;
                        r_qc <= r_qc + QCW'(1);
                    end
                end
                ST_LEARN: begin
                    if (r_chit) begin
                        r_cmac[r_cidx] <= r_job.mac; r_cst[r_cidx] <= r_now;
                    end else begin
                        r_cv[r_cold] <= 1'b1;
                        r_cip[r_cold] <= r_job.ip;
                        r_cmac[r_cold] <= r_job.mac;
                        r_cst[r_cold] <= r_now;
                    end
                    if (r_rhit) r_rv[r_ridx] <= 1'b0;
                    r_i <= '0;
                end
                ST_FLUSH: begin
                    if (q_more) begin
                        if (q_match) begin
                            if (!r_hold || slot_free) begin
                                r_htag <= r_ptag[qi];
                                r_hold <= 1'b1;
                                r_i <= r_i + 9'd1;
                            end
                        end else begin
                            // keep the rest packed from the head
                            r_pip[r_k[QW-1:0]] <= r_pip[qi];
                            r_ptag[r_k[QW-1:0]] <= r_ptag[qi];
                            r_k <= r_k + QCW'(1);
                            r_i <= r_i + 9'd1;
                        end
                    end else begin
                        r_qc <= r_k;
                    end
                end
                ST_AGE: begin
                    r_i <= r_i + 9'd1;
                    if (ci_ok && r_cv[ci] && cage > {32'd0, i_lifetime})
                        r_cv[ci] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (do_emit) r_o <= n_o;
    end
endmodule

// ----- hdl/arp_resolver_with_pending_queue.sv -----
// top level of the arp resolver with pending datagram queue
`timescale 1ns / 1ps
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    action and frame fields
//  out_ch    out  valid/ready    results of each event, last on the final one
//  cfg_ch    in   valid/ready    register index and data
//  a send leaves the front queue, scans cache and request table one entry a cycle,
//  then decides and, on a cache miss, queues
//  an arp frame scans, learns, flushes matching queued datagrams and may reply
//  a tick runs the aging sweep over the cache; an ipv4 delivery needs no scan
//  reset is synchronous and clears all valid bits and the time counter
//  a stalled output holds the back end; the front queue takes up to two requests
module arp_resolver_with_pending_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    arp_in_if.sink    in_ch,
    arp_out_if.source out_ch,
    arp_cfg_if.sink   cfg_ch
);
    import arp_pkg::*;

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic [15:0] r_retry;
    logic [31:0] r_life;

    // configuration registers, always writable
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
            r_retry   <= RETRY_RESET;
            r_life    <= LIFETIME_RESET;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_OWN_MAC:  r_own_mac <= cfg_ch.data;
                REG_OWN_IP:   r_own_ip  <= cfg_ch.data[31:0];
                REG_RETRY:    r_retry   <= cfg_ch.data[15:0];
                REG_LIFETIME: r_life    <= cfg_ch.data[31:0];
                default: ;
            endcase
        end
    end

    logic  job_valid, job_ready, dlv_valid, dlv_ready;
    t_job  job;
    logic [15:0] dlv_tag;

    // front classifies, back executes
    arp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .i_own_mac(r_own_mac), .i_own_ip(r_own_ip),
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready),
        .o_dlv_valid(dlv_valid), .o_dlv_tag(dlv_tag), .i_dlv_ready(dlv_ready)
    );

    arp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job(job), .o_job_ready(job_ready),
        .i_dlv_valid(dlv_valid), .i_dlv_tag(dlv_tag), .o_dlv_ready(dlv_ready),
        .i_retry(r_retry), .i_lifetime(r_life), .out_ch(out_ch)
    );
endmodule

// ----- hdl/arp_checker.sv -----
// port-level checker for the arp resolver, bound to the top level
`timescale 1ns / 1ps
`include "arp_resolver_with_pending_queue_defines.svh"
module arp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_kind,
    input logic        out_last,
    input logic [47:0] out_dst
);
    import arp_pkg::*;
    `ARP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `ARP_ASSERT_IMP(a_kind, i_clk, i_rst_n, out_valid, out_kind <= KIND_DROP)
    `ARP_ASSERT_IMP(a_req_bc, i_clk, i_rst_n, out_valid && out_kind == KIND_ARP_REQ,
        out_dst == MAC_BCAST)
    `ARP_ASSERT_IMP(a_dlv_last, i_clk, i_rst_n, out_valid && out_kind == KIND_DELIVER,
        out_last)
endmodule

bind arp_resolver_with_pending_queue arp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_kind(out_ch.kind), .out_last(out_ch.last),
    .out_dst(out_ch.dst_mac)
);

// ----- tb/arp_tb_if.sv -----
// request item type of the arp resolver testbench
`timescale 1ns / 1ps
package arp_tb_types;
    import arp_pkg::*;

    // one request item as offered on the input channel
    typedef struct {
        logic [1:0]  action;
        logic [31:0] hop;
        logic [15:0] tag;
        logic [47:0] fdst;
        logic [15:0] etype;
        logic        ok;
        logic [15:0] op;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [31:0] tip;
        logic [31:0] elapsed;
    } t_req;
endpackage

// ----- tb/tb.sv -----
// self-checking testbench of the arp resolver with pending queue
`timescale 1ns / 1ps
module tb;
    import arp_pkg::*;
    import arp_tb_types::*;

    localparam int LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    arp_in_if  in_ch();
    arp_out_if out_ch();
    arp_cfg_if cfg_ch();

    arp_resolver_with_pending_queue u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    // predictor copy of the resolver state
    logic [47:0] m_own_mac;
    logic [31:0] m_own_ip;
    logic [15:0] m_retry;
    logic [31:0] m_life;
    logic [63:0] m_now;
    logic        c_v [16];
    logic [31:0] c_ip [16];
    logic [47:0] c_mac [16];
    logic [63:0] c_st [16];
    logic        r_v [16];
    logic [31:0] r_ip [16];
    logic [63:0] r_st [16];
    logic [31:0] q_ip [$];
    logic [15:0] q_tag [$];

    t_req   pending_reqs [$];
    t_res   expected_results [$];
    int     fails = 0;
    longint cycle = 0;
    bit     quiet;       // last phase: no idling
    bit     hold_go;     // asks for the long receiver stall
    bit     hold_seen;
    int     hold_off;    // long receiver stall in cycles
    int     tx_gap, rx_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void emit(logic [2:0] k, logic [47:0] d, logic [15:0] t,
                                 logic [31:0] ip, logic [47:0] m);
        t_res r;
        r.kind = k; r.dst_mac = d; r.out_tag = t;
        r.arp_target_ip_out = ip; r.arp_target_mac_out = m; r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    // lowest free slot, else oldest stamp, lowest index on ties
    function automatic int free_or_oldest(logic v [16], logic [63:0] st [16]);
        int best;
        logic [63:0] age, best_age;
        best = 0;
        best_age = 0;
        for (int i = 0; i < 16; i++)
            if (!v[i]) return i;
        for (int i = 0; i < 16; i++) begin
            age = m_now - st[i];
            if (i == 0 || age > best_age) begin
                best = i; best_age = age;
            end
        end
        return best;
    endfunction

    function automatic void resolve(t_req q);
        int n_before, c, r, k;
        logic [31:0] kip [$];
        logic [15:0] ktag [$];
        n_before = expected_results.size();
        if (q.action == ACT_SEND) begin
            c = -1; r = -1;
            for (int i = 0; i < 16; i++) if (c < 0 && c_v[i] && c_ip[i] == q.hop) c = i;
            if (c >= 0) emit(KIND_IPV4, c_mac[c], q.tag, '0, '0);
            else begin
                for (int i = 0; i < 16; i++)
                    if (r < 0 && r_v[i] && r_ip[i] == q.hop) r = i;
                if (r < 0 || m_now - r_st[r] > {48'd0, m_retry}) begin
                    emit(KIND_ARP_REQ, MAC_BCAST, '0, q.hop, '0);
                    if (r < 0) begin
                        r = free_or_oldest(r_v, r_st);
                        r_v[r] = 1'b1; r_ip[r] = q.hop;
                    end
                    r_st[r] = m_now;
                end
                if (q_ip.size() < QUEUE_DEPTH) begin
                    q_ip.push_back(q.hop); q_tag.push_back(q.tag);
                end else emit(KIND_DROP, '0, q.tag, '0, '0);
            end
        end else if (q.action == ACT_RECV) begin
            if ((q.fdst == m_own_mac || q.fdst == MAC_BCAST) && q.ok) begin
                if (q.etype == ETH_IPV4) emit(KIND_DELIVER, '0, q.tag, '0, '0);
                else if (q.etype == ETH_ARP) begin
                    c = -1; r = -1;
                    for (int i = 0; i < 16; i++)
                        if (c < 0 && c_v[i] && c_ip[i] == q.sip) c = i;
                    if (c < 0) begin
                        c = free_or_oldest(c_v, c_st);
                        c_v[c] = 1'b1; c_ip[c] = q.sip;
                    end
                    c_mac[c] = q.smac; c_st[c] = m_now;
                    for (int i = 0; i < 16; i++)
                        if (r < 0 && r_v[i] && r_ip[i] == q.sip) r = i;
                    if (r >= 0) r_v[r] = 1'b0;
                    // flush matching datagrams in order, keep the rest packed
                    for (k = 0; k < q_ip.size(); k++) begin
                        if (q_ip[k] == q.sip) emit(KIND_IPV4, q.smac, q_tag[k], '0, '0);
                        else begin
                            kip.push_back(q_ip[k]); ktag.push_back(q_tag[k]);
                        end
                    end
                    q_ip = kip; q_tag = ktag;
                    if (q.op == ARP_OP_REQUEST && q.tip == m_own_ip)
                        emit(KIND_ARP_REP, q.smac, '0, q.sip, q.smac);
                end
            end
        end else if (q.action == ACT_TICK) begin
            m_now += {32'd0, q.elapsed};
            for (int i = 0; i < 16; i++)
                if (c_v[i] && m_now - c_st[i] > {32'd0, m_life}) c_v[i] = 1'b0;
        end
        if (expected_results.size() > n_before)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // request builders
    function automatic t_req blank_req(logic [1:0] a);
        t_req q;
        q.action = a; q.hop = $urandom; q.tag = 16'($urandom);
        q.fdst = 48'({$urandom, $urandom}); q.etype = 16'($urandom); q.ok = 1'($urandom);
        q.op = 16'($urandom); q.sip = $urandom; q.smac = 48'({$urandom, $urandom});
        q.tip = $urandom; q.elapsed = $urandom;
        return q;
    endfunction

    function automatic t_req send_req(logic [31:0] ip, logic [15:0] t);
        t_req q;
        q = blank_req(ACT_SEND); q.hop = ip; q.tag = t;
        return q;
    endfunction

    function automatic t_req arp_req(logic [31:0] sip, logic [47:0] smac,
                                     logic [15:0] op, logic [31:0] tip);
        t_req q;
        q = blank_req(ACT_RECV);
        q.fdst = ($urandom_range(0, 1) != 0) ? MAC_BCAST : m_own_mac;
        q.etype = ETH_ARP; q.ok = 1'b1; q.op = op; q.sip = sip;
        q.smac = smac; q.tip = tip;
        return q;
    endfunction

    function automatic t_req tick_req(logic [31:0] ms);
        t_req q;
        q = blank_req(ACT_TICK); q.elapsed = ms;
        return q;
    endfunction

    // driver: offers requests from the pending queue with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid            <= 1'b0;
            in_ch.action           <= '0;
            in_ch.next_hop_ip      <= '0;
            in_ch.payload_tag      <= '0;
            in_ch.frame_dst_mac    <= '0;
            in_ch.ether_type       <= '0;
            in_ch.parse_ok         <= 1'b0;
            in_ch.arp_opcode       <= '0;
            in_ch.arp_sender_ip    <= '0;
            in_ch.arp_sender_mac   <= '0;
            in_ch.arp_target_ip_in <= '0;
            in_ch.elapsed_ms       <= '0;
            tx_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) resolve(pending_reqs.pop_front());
            if (tx_gap > 0 && !(in_ch.valid && !in_ch.ready)) begin
                tx_gap <= tx_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (!in_ch.valid || in_ch.ready) begin
                if (pending_reqs.size() > 0 && !quiet && $urandom_range(0, 19) == 0) begin
                    tx_gap <= $urandom_range(1, 16) - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_ch.valid            <= 1'b1;
                    in_ch.action           <= pending_reqs[0].action;
                    in_ch.next_hop_ip      <= pending_reqs[0].hop;
                    in_ch.payload_tag      <= pending_reqs[0].tag;
                    in_ch.frame_dst_mac    <= pending_reqs[0].fdst;
                    in_ch.ether_type       <= pending_reqs[0].etype;
                    in_ch.parse_ok         <= pending_reqs[0].ok;
                    in_ch.arp_opcode       <= pending_reqs[0].op;
                    in_ch.arp_sender_ip    <= pending_reqs[0].sip;
                    in_ch.arp_sender_mac   <= pending_reqs[0].smac;
                    in_ch.arp_target_ip_in <= pending_reqs[0].tip;
                    in_ch.elapsed_ms       <= pending_reqs[0].elapsed;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 0;
            hold_seen <= 1'b0;
        end else if (hold_go && !hold_seen) begin
            hold_off <= 600;
            hold_seen <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // monitor: compares every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind %0d", out_ch.kind);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    if (out_ch.kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, out_ch.kind); fails++;
                    end
                    if (out_ch.dst_mac !== e.dst_mac) begin
                        $error("dst_mac exp %h got %h", e.dst_mac, out_ch.dst_mac); fails++;
                    end
                    if (out_ch.out_tag !== e.out_tag) begin
                        $error("out_tag exp %h got %h", e.out_tag, out_ch.out_tag); fails++;
                    end
                    if (out_ch.arp_target_ip_out !== e.arp_target_ip_out) begin
                        $error("arp_target_ip_out exp %h got %h", e.arp_target_ip_out,
                               out_ch.arp_target_ip_out); fails++;
                    end
                    if (out_ch.arp_target_mac_out !== e.arp_target_mac_out) begin
                        $error("arp_target_mac_out exp %h got %h", e.arp_target_mac_out,
                               out_ch.arp_target_mac_out); fails++;
                    end
                    if (out_ch.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, out_ch.last); fails++;
                    end
                end
            end
            if (hold_off > 0) begin
                out_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                rx_gap <= $urandom_range(1, 16) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_OWN_MAC:  m_own_mac = val;
            REG_OWN_IP:   m_own_ip = val[31:0];
            REG_RETRY:    m_retry = val[15:0];
            REG_LIFETIME: m_life = val[31:0];
            default: ;
        endcase
    endtask

    // wait until the block has drained everything queued so far
    task automatic drain();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // a burst of mostly well formed traffic over a small ip pool
    task automatic random_phase(int n);
        logic [31:0] pool [8];
        logic [31:0] ip;
        int sel;
        for (int i = 0; i < 8; i++) pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
        for (int i = 0; i < n; i++) begin
            ip = pool[$urandom_range(0, 7)];
            sel = $urandom_range(0, 99);
            if (sel < 40) pending_reqs.push_back(send_req(ip, 16'($urandom)));
            else if (sel < 65) pending_reqs.push_back(arp_req(ip, 48'({$urandom, $urandom}),
                ($urandom_range(0, 2) == 0) ? 16'd2 : 16'd1,
                ($urandom_range(0, 1) != 0) ? m_own_ip : $urandom));
            else if (sel < 75) pending_reqs.push_back(tick_req($urandom_range(0, 3) == 0 ?
                $urandom : $urandom_range(0, 8000)));
            else if (sel < 82) begin
                pending_reqs.push_back(blank_req(ACT_RECV));
                pending_reqs[$].fdst = m_own_mac; pending_reqs[$].etype = ETH_IPV4;
                pending_reqs[$].ok = 1'b1;
            end else if (sel < 88) pending_reqs.push_back(send_req($urandom, 16'($urandom)));
            else pending_reqs.push_back(blank_req(2'($urandom_range(0, 3))));
        end
    endtask

    initial begin
        quiet = 0; hold_go = 0;
        m_own_mac = 0; m_own_ip = 0; m_retry = RETRY_RESET; m_life = LIFETIME_RESET;
        m_now = 0;
        for (int i = 0; i < 16; i++) begin
            c_v[i] = 0; r_v[i] = 0;
        end
        i_rst_n = 1'b0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (40) @(posedge i_clk);

        // directed: default registers, then set addresses
        pending_reqs.push_back(send_req(32'h0A00_0001, 16'h0000));
        pending_reqs.push_back(send_req(32'h0A00_0001, 16'hFFFF));
        drain();
        write_reg(REG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_OWN_IP, 48'hFFFF_FFFF);
        write_reg(REG_RETRY, 48'd0);
        write_reg(REG_LIFETIME, 48'd0);
        pending_reqs.push_back(arp_req(32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 16'd1, 32'hFFFF_FFFF));
        pending_reqs.push_back(send_req(32'h0A00_0001, 16'h1234));
        pending_reqs.push_back(tick_req(32'd1));
        pending_reqs.push_back(send_req(32'h0A00_0001, 16'h0001));
        pending_reqs.push_back(tick_req(32'hFFFF_FFFF));
        drain();
        write_reg(REG_OWN_MAC, 48'h0200_0000_0001);
        write_reg(REG_OWN_IP, 48'hC0A8_0001);
        write_reg(REG_RETRY, 48'hFFFF);
        write_reg(REG_LIFETIME, 48'hFFFF_FFFF);
        // queue overflow, then flush through an arp reply
        for (int i = 0; i < 18; i++)
            pending_reqs.push_back(send_req(32'h0B00_0000 + 32'(i % 2), 16'(i)));
        pending_reqs.push_back(arp_req(32'h0B00_0000, 48'h0000_0000_0000, 16'd2, 32'd0));
        pending_reqs.push_back(arp_req(32'h0B00_0001, 48'h0A0B_0C0D_0E0F, 16'd1, 32'hC0A8_0001));
        // ignored frames
        pending_reqs.push_back(blank_req(2'd3));
        pending_reqs.push_back(blank_req(ACT_RECV));
        pending_reqs[$].fdst = 48'h1111_2222_3333; pending_reqs[$].ok = 1'b1;
        drain();

        // cache replacement with all 16 entries used
        for (int i = 0; i < 20; i++) begin
            pending_reqs.push_back(arp_req(32'h2000_0000 + 32'(i), 48'($urandom), 16'd2, 32'd0));
            pending_reqs.push_back(tick_req(32'(i)));
        end
        drain();
        // long receiver stall while sends keep coming
        hold_go = 1;
        for (int i = 0; i < 40; i++)
            pending_reqs.push_back(send_req(32'h2000_0000 + 32'(i), 16'(i)));
        drain();

        random_phase(110);
        drain();
        write_reg(REG_RETRY, 48'($urandom_range(0, 6000)));
        write_reg(REG_LIFETIME, 48'($urandom_range(0, 40000)));
        write_reg(REG_OWN_IP, 48'($urandom));
        random_phase(110);
        drain();
        write_reg(REG_OWN_MAC, 48'({$urandom, $urandom}));
        quiet = 1;
        random_phase(50);
        drain();

        if (fails == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule
